// ===== design/cmdr_pkg.sv =====
// Shared types, widths, codes and helpers of the chassis command ramp.
package cmdr_pkg;

    localparam int LEVER_W = 11;
    localparam int SW_W    = 2;
    localparam int VEL_W   = 14;
    localparam int CALC_W  = 16;
    localparam int STEP_W  = 10;
    localparam int LIM_W   = 13;
    localparam int HOLD_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 13;

    localparam logic [LEVER_W:0] LEVER_CENTRE = 12'h400;

    // Switch codes
    localparam logic [SW_W-1:0] LS_UP    = 2'd1;
    localparam logic [SW_W-1:0] RS_LEVER = 2'd1;
    localparam logic [SW_W-1:0] RS_SHOT  = 2'd2;
    localparam logic [SW_W-1:0] RS_KEY   = 2'd3;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] CFG_FOLLOW_MODE = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_ACC_STEP    = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_DEC_STEP    = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_XY_LIMIT    = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_W_LIMIT     = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_SLOW_LIMIT  = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_HOLD_TICKS  = 3'd6;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0] ACC_STEP_RST   = 10'd20;
    localparam logic [STEP_W-1:0] DEC_STEP_RST   = 10'd20;
    localparam logic [LIM_W-1:0]  XY_LIMIT_RST   = 13'd3000;
    localparam logic [LIM_W-1:0]  W_LIMIT_RST    = 13'd2000;
    localparam logic [LIM_W-1:0]  SLOW_LIMIT_RST = 13'd500;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 8'd20;

    typedef logic signed [VEL_W-1:0] t_vel;

    // Per-axis control for one tick
    typedef struct packed {
        logic load;    // take the lever value
        logic clear;   // left switch kill
        logic ramp_en; // key mode ramp or decay
        logic dn;      // subtract acc step (wins over up)
        logic up;      // add acc step
    } t_axis_ctl;

    // Centre a raw lever reading and scale by five.
    function automatic t_vel lever_scale(input logic [LEVER_W-1:0] raw);
        t_vel c;
        c = t_vel'({1'b0, raw}) - t_vel'(LEVER_CENTRE);
        return (c <<< 2) + c;
    endfunction

endpackage

// ===== design/cmdr_if.sv =====
// Channel interfaces: command input, velocity output and configuration write.
interface cmdr_in_if
    import cmdr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LEVER_W-1:0] lever_horizontal;
    logic [LEVER_W-1:0] lever_vertical;
    logic [SW_W-1:0]    left_switch;
    logic [SW_W-1:0]    right_switch;
    logic               key_shift;
    logic               key_w;
    logic               key_s;
    logic               key_a;
    logic               key_d;
    logic               key_q;
    logic               key_e;

    modport source (
        output valid, lever_horizontal, lever_vertical, left_switch, right_switch,
               key_shift, key_w, key_s, key_a, key_d, key_q, key_e,
        input  ready
    );
    modport sink (
        input  valid, lever_horizontal, lever_vertical, left_switch, right_switch,
               key_shift, key_w, key_s, key_a, key_d, key_q, key_e,
        output ready
    );
endinterface

interface cmdr_out_if
    import cmdr_pkg::*;
();
    logic valid;
    logic ready;
    t_vel out_vel_x;
    t_vel out_vel_y;
    t_vel out_vel_w;

    modport source (output valid, out_vel_x, out_vel_y, out_vel_w, input ready);
    modport sink (input valid, out_vel_x, out_vel_y, out_vel_w, output ready);
endinterface

interface cmdr_cfg_if
    import cmdr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== design/cmdr_axis.sv =====
// One velocity axis: lever load, key ramp or decay, kill, symmetric clamp.
module cmdr_axis
    import cmdr_pkg::*;
(
    input  t_vel              i_cur,
    input  t_vel              i_lever,
    input  t_axis_ctl         i_ctl,
    input  logic [STEP_W-1:0] i_acc,
    input  logic [STEP_W-1:0] i_dec,
    input  logic [LIM_W-1:0]  i_limit,
    output t_vel              o_next
);
    logic signed [CALC_W-1:0] v;
    logic signed [CALC_W-1:0] acc;
    logic signed [CALC_W-1:0] dec;
    logic signed [CALC_W-1:0] lim;
    logic signed [CALC_W-1:0] ramped;
    logic signed [CALC_W-1:0] pre;

    always_comb begin
        v   = CALC_W'(i_cur);
        acc = $signed({{(CALC_W-STEP_W){1'b0}}, i_acc});
        dec = $signed({{(CALC_W-STEP_W){1'b0}}, i_dec});
        lim = $signed({{(CALC_W-LIM_W){1'b0}}, i_limit});

        // Ramp on a held key, otherwise decay toward zero.
        priority if (i_ctl.dn) begin
            ramped = v - acc;
        end else if (i_ctl.up) begin
            ramped = v + acc;
        end else if (v > -dec && v < dec) begin
            ramped = '0;
        end else if (v > 0) begin
            ramped = v - dec;
        end else if (v < 0) begin
            ramped = v + dec;
        end else begin
            ramped = v;
        end

        priority if (i_ctl.clear) begin
            pre = '0;
        end else if (i_ctl.load) begin
            pre = CALC_W'(i_lever);
        end else if (i_ctl.ramp_en) begin
            pre = ramped;
        end else begin
            pre = v;
        end

        priority if (pre <= -lim) begin
            o_next = VEL_W'(-lim);
        end else if (pre >= lim) begin
            o_next = VEL_W'(lim);
        end else begin
            o_next = VEL_W'(pre);
        end
    end
endmodule

// ===== design/chassis_command_ramp_top.sv =====
// Top level of the chassis command ramp: control regs, tick decode, three axes.
//
//  channel | dir | transfer payload
//  --------+-----+---------------------------------------------------------
//  i_cmd   | in  | two levers, two three-way switches, seven key bits
//  o_vel   | out | clamped X, Y and W velocity commands after the tick
//  i_cfg   | in  | register index and write data (follow mode, steps, limits)
//
//  Every command transfer yields one velocity transfer; one command per cycle
//  is sustained while o_vel is ready, set by the single pass through the axis
//  logic into the velocity registers, which double as the result register.
//  The command side stays ready while the result register is empty or is
//  being taken, so a stall on o_vel holds i_cmd only as long as it lasts.
//  Reset (synchronous, active low) zeroes velocities, the hold counter and
//  slow mode, and loads the default configuration. Config is always ready.
module chassis_command_ramp_top
    import cmdr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    cmdr_in_if.sink           i_cmd,
    cmdr_out_if.source        o_vel,
    cmdr_cfg_if.sink          i_cfg
);
    // Configuration registers
    logic              r_follow;
    logic [STEP_W-1:0] r_acc_step;
    logic [STEP_W-1:0] r_dec_step;
    logic [LIM_W-1:0]  r_xy_limit;
    logic [LIM_W-1:0]  r_w_limit;
    logic [LIM_W-1:0]  r_slow_limit;
    logic [HOLD_W-1:0] r_hold_ticks;

    // Tick state; velocities are also the presented result
    t_vel              r_vel_x, r_vel_y, r_vel_w;
    logic [HOLD_W-1:0] r_hold_cnt;
    logic              r_slow;
    logic              r_out_valid;

    t_vel              n_vel_x, n_vel_y, n_vel_w;
    logic [HOLD_W-1:0] n_hold_cnt;
    logic              n_slow;

    logic              accept;
    logic              cfg_wr;
    logic              lever_mode, key_mode, shot_mode;
    logic              hold_hit;
    logic              kill;
    logic [HOLD_W-1:0] hold_base;
    logic [LIM_W-1:0]  lim_xy, lim_w;
    t_vel              lev_h, lev_v;
    t_axis_ctl         ctl_x, ctl_y, ctl_w;

    assign i_cmd.ready = !r_out_valid || o_vel.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    assign o_vel.valid     = r_out_valid;
    assign o_vel.out_vel_x = r_vel_x;
    assign o_vel.out_vel_y = r_vel_y;
    assign o_vel.out_vel_w = r_vel_w;

    // Decode the tick
    always_comb begin
        lever_mode = i_cmd.right_switch == RS_LEVER;
        key_mode   = i_cmd.right_switch == RS_KEY;
        shot_mode  = i_cmd.right_switch == RS_SHOT;
        hold_hit   = r_hold_cnt >= r_hold_ticks;
        kill       = lever_mode && hold_hit && (i_cmd.left_switch == LS_UP);

        // In lever or shot mode, saturate the hold count at hold_ticks+1 once reached, then count.
        hold_base  = ((lever_mode || shot_mode) && hold_hit) ? r_hold_ticks + 1'b1
                                                             : r_hold_cnt;
        n_hold_cnt = hold_base + 1'b1;

        // Slow mode follows shift in key mode and persists otherwise.
        n_slow = key_mode ? i_cmd.key_shift : r_slow;
        lim_xy = n_slow ? r_slow_limit : r_xy_limit;
        lim_w  = n_slow ? r_slow_limit : r_w_limit;

        lev_h = lever_scale(i_cmd.lever_horizontal);
        lev_v = lever_scale(i_cmd.lever_vertical);

        // X: lever in follow mode; keys D/A in follow mode, Q/E when separated.
        ctl_x.load    = lever_mode && r_follow;
        ctl_x.clear   = kill;
        ctl_x.ramp_en = key_mode;
        ctl_x.dn      = r_follow ? i_cmd.key_d : (i_cmd.key_e && !i_cmd.key_q);
        ctl_x.up      = r_follow ? i_cmd.key_a : i_cmd.key_q;

        // Y: lever in both drives, W/S keys.
        ctl_y.load    = lever_mode;
        ctl_y.clear   = kill;
        ctl_y.ramp_en = key_mode;
        ctl_y.dn      = i_cmd.key_w;
        ctl_y.up      = i_cmd.key_s;

        // W: only when separated, A/D keys.
        ctl_w.load    = lever_mode && !r_follow;
        ctl_w.clear   = kill;
        ctl_w.ramp_en = key_mode && !r_follow;
        ctl_w.dn      = i_cmd.key_a;
        ctl_w.up      = i_cmd.key_d;
    end

    cmdr_axis u_axis_x (
        .i_cur(r_vel_x), .i_lever(-lev_h), .i_ctl(ctl_x),
        .i_acc(r_acc_step), .i_dec(r_dec_step), .i_limit(lim_xy), .o_next(n_vel_x)
    );

    cmdr_axis u_axis_y (
        .i_cur(r_vel_y), .i_lever(-lev_v), .i_ctl(ctl_y),
        .i_acc(r_acc_step), .i_dec(r_dec_step), .i_limit(lim_xy), .o_next(n_vel_y)
    );

    cmdr_axis u_axis_w (
        .i_cur(r_vel_w), .i_lever(lev_h), .i_ctl(ctl_w),
        .i_acc(r_acc_step), .i_dec(r_dec_step), .i_limit(lim_w), .o_next(n_vel_w)
    );

    // Advance state on a command transfer; drop valid once the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_x     <= '0;
            r_vel_y     <= '0;
            r_vel_w     <= '0;
            r_hold_cnt  <= '0;
            r_slow      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_vel_x     <= n_vel_x;
                r_vel_y     <= n_vel_y;
                r_vel_w     <= n_vel_w;
                r_hold_cnt  <= n_hold_cnt;
                r_slow      <= n_slow;
                r_out_valid <= 1'b1;
            end else if (o_vel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_follow     <= 1'b0;
            r_acc_step   <= ACC_STEP_RST;
            r_dec_step   <= DEC_STEP_RST;
            r_xy_limit   <= XY_LIMIT_RST;
            r_w_limit    <= W_LIMIT_RST;
            r_slow_limit <= SLOW_LIMIT_RST;
            r_hold_ticks <= HOLD_TICKS_RST;
        end else if (cfg_wr) begin
            unique case (i_cfg.addr)
                CFG_FOLLOW_MODE: r_follow     <= i_cfg.wdata[0];
                CFG_ACC_STEP:    r_acc_step   <= i_cfg.wdata[STEP_W-1:0];
                CFG_DEC_STEP:    r_dec_step   <= i_cfg.wdata[STEP_W-1:0];
                CFG_XY_LIMIT:    r_xy_limit   <= i_cfg.wdata[LIM_W-1:0];
                CFG_W_LIMIT:     r_w_limit    <= i_cfg.wdata[LIM_W-1:0];
                CFG_SLOW_LIMIT:  r_slow_limit <= i_cfg.wdata[LIM_W-1:0];
                CFG_HOLD_TICKS:  r_hold_ticks <= i_cfg.wdata[HOLD_W-1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A result stuck on the output must not be overwritten.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_vel.ready |=>
            $stable(r_vel_x) && $stable(r_vel_y) && $stable(r_vel_w))
        else $error("velocity changed under a stalled result");

    // Every command transfer presents a result next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("command transfer without result");

    // The hold counter moves only on a command transfer.
    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_hold_cnt) && $stable(r_slow))
        else $error("tick state moved without a transfer");

    // Left switch kill zeroes all three axes.
    a_kill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && kill |=> r_vel_x == '0 && r_vel_y == '0 && r_vel_w == '0)
        else $error("kill left a nonzero velocity");

    // Key mode latches shift into slow mode.
    a_slow_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && key_mode |=> r_slow == $past(i_cmd.key_shift))
        else $error("slow mode did not follow shift");
`endif
endmodule

// ===== tb/cmdr_vel_checker.sv =====
`timescale 1ns / 100ps
// Velocity checker: predicts every command tick and compares the velocity transfers.
module cmdr_vel_checker
    import cmdr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cmdr_in_if   cmd,
    cmdr_out_if  vel,
    cmdr_cfg_if  cfg,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int LEVER_GAIN = 5;
    localparam int REPORT_MAX = 10;

    typedef struct {
        t_vel x;
        t_vel y;
        t_vel w;
    } vel_set_t;

    vel_set_t vel_expect_q[$];
    int       mismatch_cnt;

    // Shadow configuration
    logic              follow_mode;
    logic [STEP_W-1:0] acc_step;
    logic [STEP_W-1:0] dec_step;
    logic [LIM_W-1:0]  xy_limit;
    logic [LIM_W-1:0]  w_limit;
    logic [LIM_W-1:0]  slow_limit;
    logic [HOLD_W-1:0] hold_ticks;

    // Shadow chassis state
    int                vx;
    int                vy;
    int                vw;
    logic [HOLD_W-1:0] hold_cnt;
    logic              slow_on;

    function automatic int ramp_axis(int v, logic dn, logic up);
        int a;
        int d;
        a = int'(acc_step);
        d = int'(dec_step);
        if (dn) return v - a;
        if (up) return v + a;
        if (v > -d && v < d) v = 0;
        if (v > 0) v -= d;
        if (v < 0) v += d;
        return v;
    endfunction

    function automatic int clamp_axis(int v, logic [LIM_W-1:0] lim);
        int l;
        l = int'(lim);
        if (v <= -l) return -l;
        if (v >= l) return l;
        return v;
    endfunction

    // Advance the shadow state by one command tick and return the velocities.
    function automatic vel_set_t advance_tick();
        int               h;
        int               v;
        logic [LIM_W-1:0] lim_xy;
        logic [LIM_W-1:0] lim_w;
        vel_set_t         r;
        h = int'(cmd.lever_horizontal) - int'(LEVER_CENTRE);
        v = int'(cmd.lever_vertical) - int'(LEVER_CENTRE);
        case (cmd.right_switch)
            RS_LEVER: begin
                if (follow_mode) begin
                    vx = -(h * LEVER_GAIN);
                    vy = -(v * LEVER_GAIN);
                end else begin
                    vw = h * LEVER_GAIN;
                    vy = -(v * LEVER_GAIN);
                end
                if (hold_cnt >= hold_ticks) begin
                    hold_cnt = hold_ticks + 8'd1;
                    if (cmd.left_switch == LS_UP) begin
                        vx = 0;
                        vy = 0;
                        vw = 0;
                    end
                end
            end
            RS_KEY: begin
                slow_on = cmd.key_shift;
                vy = ramp_axis(vy, cmd.key_w, cmd.key_s);
                if (!follow_mode) begin
                    vw = ramp_axis(vw, cmd.key_a, cmd.key_d);
                    vx = ramp_axis(vx, cmd.key_e && !cmd.key_q, cmd.key_q);
                end else begin
                    vx = ramp_axis(vx, cmd.key_d, cmd.key_a);
                end
            end
            RS_SHOT: begin
                if (hold_cnt >= hold_ticks) hold_cnt = hold_ticks + 8'd1;
            end
            default: ;
        endcase
        lim_xy = slow_on ? slow_limit : xy_limit;
        lim_w  = slow_on ? slow_limit : w_limit;
        vx = clamp_axis(vx, lim_xy);
        vy = clamp_axis(vy, lim_xy);
        vw = clamp_axis(vw, lim_w);
        hold_cnt = hold_cnt + 8'd1;
        r.x = t_vel'(vx);
        r.y = t_vel'(vy);
        r.w = t_vel'(vw);
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        vel_set_t want;
        if (!i_rst_n) begin
            follow_mode  = 1'b0;
            acc_step     = ACC_STEP_RST;
            dec_step     = DEC_STEP_RST;
            xy_limit     = XY_LIMIT_RST;
            w_limit      = W_LIMIT_RST;
            slow_limit   = SLOW_LIMIT_RST;
            hold_ticks   = HOLD_TICKS_RST;
            vx           = 0;
            vy           = 0;
            vw           = 0;
            hold_cnt     = '0;
            slow_on      = 1'b0;
            mismatch_cnt = 0;
            vel_expect_q.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    CFG_FOLLOW_MODE: follow_mode = cfg.wdata[0];
                    CFG_ACC_STEP:    acc_step    = cfg.wdata[STEP_W-1:0];
                    CFG_DEC_STEP:    dec_step    = cfg.wdata[STEP_W-1:0];
                    CFG_XY_LIMIT:    xy_limit    = cfg.wdata[LIM_W-1:0];
                    CFG_W_LIMIT:     w_limit     = cfg.wdata[LIM_W-1:0];
                    CFG_SLOW_LIMIT:  slow_limit  = cfg.wdata[LIM_W-1:0];
                    CFG_HOLD_TICKS:  hold_ticks  = cfg.wdata[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (vel.valid && vel.ready) begin
                if (vel_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%t unexpected velocity x=%0d y=%0d w=%0d", $realtime,
                                 vel.out_vel_x, vel.out_vel_y, vel.out_vel_w);
                end else begin
                    want = vel_expect_q.pop_front();
                    if (want.x !== vel.out_vel_x || want.y !== vel.out_vel_y ||
                        want.w !== vel.out_vel_w) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("%t velocity mismatch: exp x=%0d y=%0d w=%0d, got x=%0d y=%0d w=%0d",
                                     $realtime, want.x, want.y, want.w,
                                     vel.out_vel_x, vel.out_vel_y, vel.out_vel_w);
                    end
                end
            end
            if (cmd.valid && cmd.ready) vel_expect_q.push_back(advance_tick());
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= vel_expect_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench top: command stimulus, config phases and the verdict for the chassis ramp.
module tb;
    import cmdr_pkg::*;

    // Switch codes the package leaves unnamed
    localparam logic [SW_W-1:0] LS_NONE = 2'd0;
    localparam logic [SW_W-1:0] LS_DOWN = 2'd2;
    localparam logic [SW_W-1:0] LS_MID  = 2'd3;
    localparam logic [SW_W-1:0] RS_NONE = 2'd0;

    // Key bits in the order {shift, w, s, a, d, q, e}
    localparam logic [6:0] K_NONE  = 7'b0000000;
    localparam logic [6:0] K_SHIFT = 7'b1000000;
    localparam logic [6:0] K_W     = 7'b0100000;
    localparam logic [6:0] K_S     = 7'b0010000;
    localparam logic [6:0] K_A     = 7'b0001000;
    localparam logic [6:0] K_D     = 7'b0000100;
    localparam logic [6:0] K_Q     = 7'b0000010;
    localparam logic [6:0] K_E     = 7'b0000001;

    localparam int LEVER_MAX      = 2047;
    localparam int BUSY_PCT       = 74;
    localparam int BOTH_PCT       = 23;
    localparam int TICKS_PER_MIX  = 30;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RESET_CYCLES   = 9;
    localparam int NUM_SETTINGS   = 5;

    typedef struct packed {
        logic [LEVER_W-1:0] h;
        logic [LEVER_W-1:0] v;
        logic [SW_W-1:0]    ls;
        logic [SW_W-1:0]    rs;
        logic [6:0]         keys;
    } cmd_t;

    typedef struct packed {
        logic              follow;
        logic [STEP_W-1:0] acc;
        logic [STEP_W-1:0] dec;
        logic [LIM_W-1:0]  xy;
        logic [LIM_W-1:0]  w;
        logic [LIM_W-1:0]  slow;
        logic [HOLD_W-1:0] hold;
    } chassis_cfg_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    int   mismatches;
    int   outstanding;

    // Random-walk state of the stimulus: held keys and the selected mode persist
    logic [6:0]      held_keys = K_NONE;
    logic [SW_W-1:0] cur_mode  = RS_KEY;

    cmdr_in_if  cmd_if();
    cmdr_out_if vel_if();
    cmdr_cfg_if cfg_if();

    chassis_command_ramp_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_vel   (vel_if),
        .i_cfg   (cfg_if)
    );

    cmdr_vel_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cmd           (cmd_if),
        .vel           (vel_if),
        .cfg           (cfg_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Velocity sink: drop ready in stall_pct cycles of a hundred.
    always @(posedge i_clk) begin
        vel_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic cmd_t mk(input int h, input int v, input logic [SW_W-1:0] ls,
                                input logic [SW_W-1:0] rs, input logic [6:0] keys);
        cmd_t c;
        c.h    = h[LEVER_W-1:0];
        c.v    = v[LEVER_W-1:0];
        c.ls   = ls;
        c.rs   = rs;
        c.keys = keys;
        return c;
    endfunction

    function automatic cmd_t noise_cmd();
        logic [63:0] bits;
        cmd_t        c;
        bits = {$urandom, $urandom};
        c    = bits[$bits(cmd_t)-1:0];
        return c;
    endfunction

    // Favor the lever extremes and the centre now and then.
    function automatic logic [LEVER_W-1:0] pick_lever();
        int r;
        r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 8) return LEVER_W'(LEVER_MAX);
        if (r < 12) return LEVER_CENTRE[LEVER_W-1:0];
        return LEVER_W'($urandom_range(LEVER_MAX));
    endfunction

    // Mostly coherent driving: the mode and the held keys stay put for a
    // while so ramps can reach the clamps; a few ticks are pure noise.
    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   r;
        if ($urandom_range(99) < 8) return noise_cmd();
        if ($urandom_range(99) < 10) begin
            r = $urandom_range(99);
            if (r < 45)      cur_mode = RS_KEY;
            else if (r < 80) cur_mode = RS_LEVER;
            else if (r < 90) cur_mode = RS_SHOT;
            else             cur_mode = RS_NONE;
        end
        if ($urandom_range(99) < 15) begin
            for (int i = 0; i < 7; i++) held_keys[i] = ($urandom_range(99) < 35);
        end
        c.h    = pick_lever();
        c.v    = pick_lever();
        c.ls   = ($urandom_range(99) < 40) ? LS_UP : SW_W'($urandom_range(3));
        c.rs   = cur_mode;
        c.keys = held_keys;
        return c;
    endfunction

    task automatic drive_fields(input cmd_t c);
        cmd_if.lever_horizontal <= c.h;
        cmd_if.lever_vertical   <= c.v;
        cmd_if.left_switch      <= c.ls;
        cmd_if.right_switch     <= c.rs;
        {cmd_if.key_shift, cmd_if.key_w, cmd_if.key_s, cmd_if.key_a,
         cmd_if.key_d, cmd_if.key_q, cmd_if.key_e} <= c.keys;
    endtask

    // Offer one command and hold it until the transfer; idle cycles before it
    // carry junk on the payload with valid low.
    task automatic send_cmd(input cmd_t c);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            drive_fields(noise_cmd());
            @(posedge i_clk);
        end
        cmd_if.valid <= 1'b1;
        drive_fields(c);
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    // Stop sending, wait for every velocity still owed, then let the block settle.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all seven registers back to back; only call while idle.
    task automatic load_config(input chassis_cfg_t c);
        logic [ADDR_W-1:0] idx[7];
        logic [DATA_W-1:0] val[7];
        idx = '{CFG_FOLLOW_MODE, CFG_ACC_STEP, CFG_DEC_STEP, CFG_XY_LIMIT,
                CFG_W_LIMIT, CFG_SLOW_LIMIT, CFG_HOLD_TICKS};
        val = '{DATA_W'(c.follow), DATA_W'(c.acc), DATA_W'(c.dec), DATA_W'(c.xy),
                DATA_W'(c.w), DATA_W'(c.slow), DATA_W'(c.hold)};
        for (int i = 0; i < 7; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.addr  <= idx[i];
            cfg_if.wdata <= val[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Run random ticks under each idle mix: none, sender busy, sink busy, both.
    task automatic run_mixes();
        for (int m = 0; m < 4; m++) begin
            case (m)
                0: begin idle_pct = 0;        stall_pct <= 0;        end
                1: begin idle_pct = BUSY_PCT; stall_pct <= 0;        end
                2: begin idle_pct = 0;        stall_pct <= BUSY_PCT; end
                default: begin idle_pct = BOTH_PCT; stall_pct <= BOTH_PCT; end
            endcase
            repeat (TICKS_PER_MIX) send_cmd(rand_cmd());
        end
        idle_pct = 0;
        stall_pct <= 0;
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        chassis_cfg_t settings[NUM_SETTINGS];

        // Known values on every input before and during reset
        i_rst_n                 = 1'b0;
        idle_pct                = 0;
        stall_pct               = 0;
        vel_if.ready            = 1'b0;
        cmd_if.valid            = 1'b0;
        cmd_if.lever_horizontal = '0;
        cmd_if.lever_vertical   = '0;
        cmd_if.left_switch      = LS_NONE;
        cmd_if.right_switch     = RS_NONE;
        {cmd_if.key_shift, cmd_if.key_w, cmd_if.key_s, cmd_if.key_a,
         cmd_if.key_d, cmd_if.key_q, cmd_if.key_e} = K_NONE;
        cfg_if.valid            = 1'b0;
        cfg_if.addr             = CFG_FOLLOW_MODE;
        cfg_if.wdata            = '0;

        // Extremes of every register, a zero decay step, then two random settings
        settings[0] = '{1'b1, 10'd1000, 10'd1000, 13'd8191, 13'd8191, 13'd8191, 8'd0};
        settings[1] = '{1'b0, 10'd1, 10'd1, 13'd0, 13'd0, 13'd0, 8'd255};
        settings[2] = '{1'b0, 10'd137, 10'd0, 13'd3000, 13'd2000, 13'd500, 8'd5};
        for (int s = 3; s < NUM_SETTINGS; s++) begin
            settings[s] = '{(s == 3), STEP_W'($urandom_range(1000, 1)),
                            STEP_W'($urandom_range(1000, 1)),
                            LIM_W'($urandom_range(8191)), LIM_W'($urandom_range(8191)),
                            LIM_W'($urandom_range(8191)), HOLD_W'($urandom_range(255))};
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset config, separated drive. Counter is still below the hold
        // delay, so the left switch up must not zero anything yet.
        send_cmd(mk(0, 0, LS_UP, RS_LEVER, K_NONE));
        send_cmd(mk(LEVER_MAX, LEVER_MAX, LS_UP, RS_LEVER, K_NONE));
        send_cmd(mk(1024, 1024, LS_NONE, RS_LEVER, K_NONE));
        send_cmd(mk(1023, 1025, LS_DOWN, RS_LEVER, K_NONE));
        // All keys at once: W over S, A over D, Q over E, slow clamp
        send_cmd(mk(0, 0, LS_UP, RS_KEY, K_SHIFT | K_W | K_S | K_A | K_D | K_Q | K_E));
        send_cmd(mk(0, 0, LS_MID, RS_KEY, K_S | K_D | K_E));
        send_cmd(mk(0, 0, LS_MID, RS_KEY, K_E));
        // Release everything: decay toward zero, small values snap to zero
        send_cmd(mk(0, 0, LS_MID, RS_KEY, K_NONE));
        send_cmd(mk(0, 0, LS_MID, RS_KEY, K_NONE));
        send_cmd(mk(0, 0, LS_UP, RS_SHOT, K_W));
        send_cmd(mk(0, 0, LS_UP, RS_NONE, K_SHIFT));
        // Slow mode persists into lever mode
        send_cmd(mk(0, 0, LS_MID, RS_KEY, K_SHIFT));
        send_cmd(mk(0, LEVER_MAX, LS_MID, RS_LEVER, K_NONE));
        send_cmd(mk(0, 0, LS_MID, RS_KEY, K_NONE));

        run_mixes();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            // Pause until every velocity is back before touching config.
            wait_drained();
            load_config(settings[s]);
            if (s == 0) begin
                // Follow mode, no hold delay, widest limits and largest steps
                send_cmd(mk(0, LEVER_MAX, LS_MID, RS_LEVER, K_NONE));
                send_cmd(mk(0, 0, LS_UP, RS_LEVER, K_NONE));
                send_cmd(mk(LEVER_MAX, 0, LS_DOWN, RS_LEVER, K_NONE));
                send_cmd(mk(0, 0, LS_MID, RS_KEY, K_D | K_A));
                send_cmd(mk(0, 0, LS_MID, RS_KEY, K_A | K_W));
                send_cmd(mk(0, 0, LS_MID, RS_KEY, K_A | K_S | K_Q | K_E));
                send_cmd(mk(0, 0, LS_MID, RS_KEY, K_NONE));
                send_cmd(mk(0, 0, LS_UP, RS_SHOT, K_NONE));
            end
            run_mixes();
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
